[hw/rtl/ofms_pkg.sv]
package ofms_pkg;

	localparam int PosW = 20;
	localparam int YawW = 13;
	localparam int HdgW = 16;
	localparam int TolW = 16;
	localparam int CntW = 16;
	localparam int AgeW = 24;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;

	typedef enum logic [2:0] {
		ST_WAIT_LINK = 3'd0,
		ST_WAIT_ODOM = 3'd1,
		ST_INIT_SP   = 3'd2,
		ST_REQ_OFFB  = 3'd3,
		ST_ARM       = 3'd4,
		ST_TAKEOFF   = 3'd5,
		ST_HOVER     = 3'd6,
		ST_COMMAND   = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_TAKEOFF_X   = 3'd0,
		REG_TAKEOFF_Y   = 3'd1,
		REG_TAKEOFF_Z   = 3'd2,
		REG_TAKEOFF_YAW = 3'd3,
		REG_REACH_TOL   = 3'd4,
		REG_INIT_TOTAL  = 3'd5,
		REG_REQ_GAP     = 3'd6,
		REG_CMD_TIMEOUT = 3'd7
	} reg_idx_t;

	localparam logic [1:0] SP_NONE = 2'd0;
	localparam logic [1:0] SP_POS  = 2'd1;
	localparam logic [1:0] SP_VEL  = 2'd2;

	localparam logic [2:0] CMD_IDLE  = 3'd0;
	localparam logic [2:0] CMD_HOVER = 3'd1;
	localparam logic [2:0] CMD_POS   = 3'd2;
	localparam logic [2:0] CMD_VEL   = 3'd3;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_CMD  = 1'b1;

	typedef struct packed {
		logic [PosW-1:0] takeoff_x;
		logic [PosW-1:0] takeoff_y;
		logic [PosW-1:0] takeoff_z;
		logic [YawW-1:0] takeoff_yaw;
		logic [TolW-1:0] reach_tol;
		logic [CntW-1:0] init_total;
		logic [AgeW-1:0] req_gap;
		logic [AgeW-1:0] cmd_timeout;
	} cfg_t;

	typedef struct packed {
		logic            func;
		logic            link_up;
		logic            odom_valid;
		logic            in_offboard;
		logic            is_armed;
		logic            cmd_enable;
		logic [2:0]      cmd_kind;
		logic [PosW-1:0] val_x;
		logic [PosW-1:0] val_y;
		logic [PosW-1:0] val_z;
		logic [HdgW-1:0] val_heading;
	} item_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [PosW-1:0] x;
		logic [PosW-1:0] y;
		logic [PosW-1:0] z;
		logic [HdgW-1:0] heading;
	} sp_t;

	typedef struct packed {
		mode_t state;
		sp_t   sp;
		logic  want_offboard;
		logic  want_arm;
	} result_t;

endpackage

[hw/rtl/offboard_flight_mode_sequencer.sv]
// Launch sequencer: walks a vehicle from link-up through takeoff to hover and
// then follows external commands.
// Input channel (in_valid/in_ready) carries one item per transfer. A tick
// (func = 0) brings status flags and odometry and yields exactly one result
// transfer on the output channel (out_valid/out_ready): the new state, the
// setpoint published on that tick and the offboard/arm request pulses. A
// command item (func = 1) only stores the command and restarts its age; it
// yields no result.
// An accepted item is held in the input register, and a tick's result is
// then loaded into the output register, whose valid drives out_valid; a
// stalled receiver can hold a tick between the two. Throughput is one item
// per cycle while no tick waits on a stalled output, limited by the
// combinational step path (three squares, a sum and a compare against the squared tolerance).
// When the receiver stalls, the finished result holds in the output register
// and one further item may wait in the input register; commands behind a
// stalled tick wait their turn so order is kept.
// Reset clears the state to wait-for-link, all counters and ages, and loads
// the configuration registers with their defaults. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at the clock edge and are meant
// for idle periods only.
module offboard_flight_mode_sequencer import ofms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic                link_up,
	input  logic                odom_valid,
	input  logic                in_offboard,
	input  logic                is_armed,
	input  logic                cmd_enable,
	input  logic [2:0]          cmd_kind,
	input  logic [PosW-1:0]     val_x,
	input  logic [PosW-1:0]     val_y,
	input  logic [PosW-1:0]     val_z,
	input  logic [HdgW-1:0]     val_heading,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          fsm_state,
	output logic [1:0]          setpoint_kind,
	output logic [PosW-1:0]     sp_x,
	output logic [PosW-1:0]     sp_y,
	output logic [PosW-1:0]     sp_z,
	output logic [HdgW-1:0]     sp_heading,
	output logic                want_offboard,
	output logic                want_arm
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free, adv_s1, step_tick, step_cmd, in_xfer;

	// Configuration registers, truncated to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.takeoff_x   <= PosW'(0);
			cfg_q.takeoff_y   <= PosW'(0);
			cfg_q.takeoff_z   <= PosW'(1500);
			cfg_q.takeoff_yaw <= YawW'(0);
			cfg_q.reach_tol   <= TolW'(150);
			cfg_q.init_total  <= CntW'(100);
			cfg_q.req_gap     <= AgeW'(500);
			cfg_q.cmd_timeout <= AgeW'(50);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TAKEOFF_X:   cfg_q.takeoff_x   <= cfg_data[PosW-1:0];
				REG_TAKEOFF_Y:   cfg_q.takeoff_y   <= cfg_data[PosW-1:0];
				REG_TAKEOFF_Z:   cfg_q.takeoff_z   <= cfg_data[PosW-1:0];
				REG_TAKEOFF_YAW: cfg_q.takeoff_yaw <= cfg_data[YawW-1:0];
				REG_REACH_TOL:   cfg_q.reach_tol   <= cfg_data[TolW-1:0];
				REG_INIT_TOTAL:  cfg_q.init_total  <= cfg_data[CntW-1:0];
				REG_REQ_GAP:     cfg_q.req_gap     <= cfg_data[AgeW-1:0];
				REG_CMD_TIMEOUT: cfg_q.cmd_timeout <= cfg_data[AgeW-1:0];
			endcase
		end
	end

	// A command always drains from the input register; a tick needs a free
	// output slot, either empty or being taken this cycle.
	assign out_free  = !valid_s2 || out_ready;
	assign adv_s1    = valid_s1 && ((item_s1.func == FUNC_CMD) || out_free);
	assign step_tick = adv_s1 && (item_s1.func == FUNC_TICK);
	assign step_cmd  = adv_s1 && (item_s1.func == FUNC_CMD);
	assign in_ready  = !valid_s1 || adv_s1;
	assign in_xfer   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.func        <= func;
			item_s1.link_up     <= link_up;
			item_s1.odom_valid  <= odom_valid;
			item_s1.in_offboard <= in_offboard;
			item_s1.is_armed    <= is_armed;
			item_s1.cmd_enable  <= cmd_enable;
			item_s1.cmd_kind    <= cmd_kind;
			item_s1.val_x       <= val_x;
			item_s1.val_y       <= val_y;
			item_s1.val_z       <= val_z;
			item_s1.val_heading <= val_heading;
		end
	end

	ofms_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_tick (step_tick),
		.step_cmd  (step_cmd),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	// Output register: load on a tick step, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= step_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (step_tick) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign fsm_state     = res_s2.state;
	assign setpoint_kind = res_s2.sp.kind;
	assign sp_x          = res_s2.sp.x;
	assign sp_y          = res_s2.sp.y;
	assign sp_z          = res_s2.sp.z;
	assign sp_heading    = res_s2.sp.heading;
	assign want_offboard = res_s2.want_offboard;
	assign want_arm      = res_s2.want_arm;

endmodule

[hw/rtl/ofms_reach.sv]
module ofms_reach import ofms_pkg::*; (
	input  logic [PosW-1:0] pos_x,
	input  logic [PosW-1:0] pos_y,
	input  logic [PosW-1:0] pos_z,
	input  logic [PosW-1:0] tgt_x,
	input  logic [PosW-1:0] tgt_y,
	input  logic [PosW-1:0] tgt_z,
	input  logic [TolW-1:0] tol,
	output logic            reached
);

	logic signed [PosW:0]       dx, dy, dz;
	logic signed [2*PosW+1:0]   sqx, sqy, sqz;
	logic        [2*PosW+2:0]   dist2;
	logic        [2*TolW-1:0]   tol2;

	// widen by one bit so the difference cannot wrap
	assign dx = $signed({pos_x[PosW-1], pos_x}) - $signed({tgt_x[PosW-1], tgt_x});
	assign dy = $signed({pos_y[PosW-1], pos_y}) - $signed({tgt_y[PosW-1], tgt_y});
	assign dz = $signed({pos_z[PosW-1], pos_z}) - $signed({tgt_z[PosW-1], tgt_z});

	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign sqz = dz * dz;

	assign dist2 = (2*PosW+3)'($unsigned(sqx)) + (2*PosW+3)'($unsigned(sqy))
		+ (2*PosW+3)'($unsigned(sqz));
	assign tol2 = tol * tol;

	assign reached = dist2 < (2*PosW+3)'(tol2);

endmodule

[hw/rtl/ofms_core.sv]
module ofms_core import ofms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_tick,
	input  logic    step_cmd,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	mode_t           state_q, state_d;
	logic [CntW-1:0] init_q, init_d, init_inc;
	logic [AgeW-1:0] req_age_q, req_age_d, req_base;
	logic [AgeW-1:0] cmd_age_q, cmd_age_d;
	logic            req_before_q, req_before_d;
	logic            cmd_seen_q;
	logic            hov_cap_q, hov_cap_d;
	logic [PosW-1:0] hov_x_q, hov_y_q, hov_z_q;
	logic [PosW-1:0] hov_x_d, hov_y_d, hov_z_d;
	logic            st_en_q;
	logic [2:0]      st_kind_q;
	logic [PosW-1:0] st_x_q, st_y_q, st_z_q;
	logic [HdgW-1:0] st_hdg_q;

	sp_t  takeoff_sp, hover_sp, cmd_sp;
	logic reached, fresh, may_req, req_fire;

	ofms_reach u_reach (
		.pos_x   (item.val_x),
		.pos_y   (item.val_y),
		.pos_z   (item.val_z),
		.tgt_x   (cfg.takeoff_x),
		.tgt_y   (cfg.takeoff_y),
		.tgt_z   (cfg.takeoff_z),
		.tol     (cfg.reach_tol),
		.reached (reached)
	);

	assign fresh   = cmd_seen_q && (cmd_age_q < cfg.cmd_timeout);
	assign may_req = !req_before_q || (req_age_q > cfg.req_gap);

	always_comb begin
		takeoff_sp.kind    = SP_POS;
		takeoff_sp.x       = cfg.takeoff_x;
		takeoff_sp.y       = cfg.takeoff_y;
		takeoff_sp.z       = cfg.takeoff_z;
		takeoff_sp.heading = {{(HdgW-YawW){cfg.takeoff_yaw[YawW-1]}}, cfg.takeoff_yaw};

		hover_sp = takeoff_sp;
		if (hov_cap_q) begin
			hover_sp.x = hov_x_q;
			hover_sp.y = hov_y_q;
			hover_sp.z = hov_z_q;
		end

		cmd_sp.kind    = (st_kind_q == CMD_POS) ? SP_POS : SP_VEL;
		cmd_sp.x       = st_x_q;
		cmd_sp.y       = st_y_q;
		cmd_sp.z       = st_z_q;
		cmd_sp.heading = st_hdg_q;
	end

	assign init_inc = (init_q == {CntW{1'b1}}) ? init_q : init_q + CntW'(1);

	always_comb begin
		state_d   = state_q;
		init_d    = init_q;
		hov_cap_d = hov_cap_q;
		hov_x_d   = hov_x_q;
		hov_y_d   = hov_y_q;
		hov_z_d   = hov_z_q;
		req_fire  = 1'b0;
		res       = '0;

		unique case (state_q)
			ST_WAIT_LINK: begin
				if (item.link_up) state_d = ST_WAIT_ODOM;
			end
			ST_WAIT_ODOM: begin
				if (item.odom_valid) begin
					state_d = ST_INIT_SP;
					init_d  = '0;
				end
			end
			ST_INIT_SP: begin
				res.sp = takeoff_sp;
				init_d = init_inc;
				if (init_inc >= cfg.init_total) state_d = ST_REQ_OFFB;
			end
			ST_REQ_OFFB: begin
				res.sp = takeoff_sp;
				if (item.in_offboard) begin
					state_d = ST_ARM;
				end else if (may_req) begin
					res.want_offboard = 1'b1;
					req_fire          = 1'b1;
				end
			end
			ST_ARM: begin
				res.sp = takeoff_sp;
				if (!item.in_offboard) begin
					state_d = ST_REQ_OFFB;
				end else if (item.is_armed) begin
					state_d = ST_TAKEOFF;
				end else if (may_req) begin
					res.want_arm = 1'b1;
					req_fire     = 1'b1;
				end
			end
			ST_TAKEOFF: begin
				res.sp = takeoff_sp;
				if (item.odom_valid && reached) begin
					hov_cap_d = 1'b1;
					hov_x_d   = item.val_x;
					hov_y_d   = item.val_y;
					hov_z_d   = item.val_z;
					state_d   = ST_HOVER;
				end
			end
			ST_HOVER: begin
				res.sp = hover_sp;
				if (!item.in_offboard) begin
					state_d = ST_REQ_OFFB;
				end else if (fresh && st_en_q) begin
					if (st_kind_q == CMD_HOVER) begin
						hov_cap_d = item.odom_valid;
						if (item.odom_valid) begin
							hov_x_d = item.val_x;
							hov_y_d = item.val_y;
							hov_z_d = item.val_z;
						end
					end else if (st_kind_q != CMD_IDLE) begin
						state_d = ST_COMMAND;
					end
				end
			end
			ST_COMMAND: begin
				if (!item.in_offboard) begin
					state_d = ST_REQ_OFFB;
				end else if (!item.is_armed) begin
					state_d = ST_ARM;
				end else if (fresh && st_en_q
					&& (st_kind_q == CMD_POS || st_kind_q == CMD_VEL)) begin
					res.sp = cmd_sp;
				end else if (!fresh || !st_en_q || st_kind_q == CMD_IDLE
					|| st_kind_q == CMD_HOVER) begin
					// fall back to hover, at the present position when odometry is valid
					hov_cap_d = item.odom_valid;
					if (item.odom_valid) begin
						hov_x_d = item.val_x;
						hov_y_d = item.val_y;
						hov_z_d = item.val_z;
					end
					state_d = ST_HOVER;
				end else begin
					// land and unknown kinds hold hover
					res.sp = hover_sp;
				end
			end
		endcase

		res.state = state_d;
	end

	always_comb begin
		req_before_d = req_before_q || req_fire;
		req_base     = req_fire ? '0 : req_age_q;
		req_age_d    = (req_base == {AgeW{1'b1}}) ? req_base : req_base + AgeW'(1);
		cmd_age_d    = (cmd_age_q == {AgeW{1'b1}}) ? cmd_age_q : cmd_age_q + AgeW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WAIT_LINK;
			init_q       <= '0;
			req_age_q    <= '0;
			req_before_q <= 1'b0;
			cmd_seen_q   <= 1'b0;
			cmd_age_q    <= '0;
			hov_cap_q    <= 1'b0;
			st_en_q      <= 1'b0;
		end else if (step_cmd) begin
			cmd_seen_q <= 1'b1;
			cmd_age_q  <= '0;
			st_en_q    <= item.cmd_enable;
		end else if (step_tick) begin
			state_q      <= state_d;
			init_q       <= init_d;
			req_age_q    <= req_age_d;
			req_before_q <= req_before_d;
			cmd_age_q    <= cmd_age_d;
			hov_cap_q    <= hov_cap_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_cmd) begin
			st_kind_q <= item.cmd_kind;
			st_x_q    <= item.val_x;
			st_y_q    <= item.val_y;
			st_z_q    <= item.val_z;
			st_hdg_q  <= item.val_heading;
		end
		if (step_tick) begin
			hov_x_q <= hov_x_d;
			hov_y_q <= hov_y_d;
			hov_z_q <= hov_z_d;
		end
	end

endmodule

[tb/ofms_tb_pkg.sv]
package ofms_tb_pkg;
	import ofms_pkg::*;

	localparam int ReportLimit = 10;

	class flight_sequence_scoreboard;
		// Register copy
		logic signed [PosW-1:0] tgt_x, tgt_y, tgt_z;
		logic signed [YawW-1:0] tgt_yaw;
		logic [TolW-1:0]        reach_tol;
		logic [CntW-1:0]        init_total;
		logic [AgeW-1:0]        req_gap;
		logic [AgeW-1:0]        cmd_timeout;

		// Sequencer state copy
		mode_t                  mode;
		logic [CntW-1:0]        init_cnt;
		logic [AgeW-1:0]        req_age;
		bit                     req_sent;
		bit                     cmd_seen;
		logic [AgeW-1:0]        cmd_age;
		bit                     cmd_en;
		logic [2:0]             cmd_kind;
		logic signed [PosW-1:0] cmd_x, cmd_y, cmd_z;
		logic signed [HdgW-1:0] cmd_hdg;
		logic signed [PosW-1:0] hov_x, hov_y, hov_z;
		bit                     hov_held;

		result_t tick_results[$];
		int      mismatches;
		int      checked;
		int      offb_pulses;
		int      arm_pulses;
		logic [7:0] modes_seen;

		function new();
			tgt_x = '0;
			tgt_y = '0;
			tgt_z = PosW'(1500);
			tgt_yaw = '0;
			reach_tol = TolW'(150);
			init_total = CntW'(100);
			req_gap = AgeW'(500);
			cmd_timeout = AgeW'(50);
			mode = ST_WAIT_LINK;
			init_cnt = '0;
			req_age = '0;
			req_sent = 1'b0;
			cmd_seen = 1'b0;
			cmd_age = '0;
			cmd_en = 1'b0;
			cmd_kind = CMD_IDLE;
			cmd_x = '0;
			cmd_y = '0;
			cmd_z = '0;
			cmd_hdg = '0;
			hov_x = '0;
			hov_y = '0;
			hov_z = '0;
			hov_held = 1'b0;
			mismatches = 0;
			checked = 0;
			offb_pulses = 0;
			arm_pulses = 0;
			modes_seen = '0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CfgDataW-1:0] d);
			case (idx)
				REG_TAKEOFF_X:   tgt_x = d[PosW-1:0];
				REG_TAKEOFF_Y:   tgt_y = d[PosW-1:0];
				REG_TAKEOFF_Z:   tgt_z = d[PosW-1:0];
				REG_TAKEOFF_YAW: tgt_yaw = d[YawW-1:0];
				REG_REACH_TOL:   reach_tol = d[TolW-1:0];
				REG_INIT_TOTAL:  init_total = d[CntW-1:0];
				REG_REQ_GAP:     req_gap = d;
				REG_CMD_TIMEOUT: cmd_timeout = d;
			endcase
		endfunction

		function sp_t takeoff_sp();
			sp_t s;
			s.kind = SP_POS;
			s.x = tgt_x;
			s.y = tgt_y;
			s.z = tgt_z;
			s.heading = {{(HdgW-YawW){tgt_yaw[YawW-1]}}, tgt_yaw};
			return s;
		endfunction

		function sp_t hover_sp();
			sp_t s;
			s = takeoff_sp();
			if (hov_held) begin
				s.x = hov_x;
				s.y = hov_y;
				s.z = hov_z;
			end
			return s;
		endfunction

		function void capture(bit valid, logic signed [PosW-1:0] x, y, z);
			hov_held = valid;
			if (valid) begin
				hov_x = x;
				hov_y = y;
				hov_z = z;
			end
		endfunction

		function void accept_item(item_t it);
			result_t r;
			mode_t nxt;
			bit fresh;
			bit may_req;
			longint dx, dy, dz, tol;
			logic signed [PosW-1:0] ox, oy, oz;
			ox = it.val_x;
			oy = it.val_y;
			oz = it.val_z;
			if (it.func == FUNC_CMD) begin
				cmd_en = it.cmd_enable;
				cmd_kind = it.cmd_kind;
				cmd_x = ox;
				cmd_y = oy;
				cmd_z = oz;
				cmd_hdg = it.val_heading;
				cmd_seen = 1'b1;
				cmd_age = '0;
				return;
			end
			r = '0;
			fresh = cmd_seen && (cmd_age < cmd_timeout);
			may_req = !req_sent || (req_age > req_gap);
			nxt = mode;
			case (mode)
				ST_WAIT_LINK: if (it.link_up) nxt = ST_WAIT_ODOM;
				ST_WAIT_ODOM: if (it.odom_valid) begin
					nxt = ST_INIT_SP;
					init_cnt = '0;
				end
				ST_INIT_SP: begin
					r.sp = takeoff_sp();
					if (init_cnt != '1) init_cnt++;
					if (init_cnt >= init_total) nxt = ST_REQ_OFFB;
				end
				ST_REQ_OFFB: begin
					r.sp = takeoff_sp();
					if (it.in_offboard) begin
						nxt = ST_ARM;
					end else if (may_req) begin
						r.want_offboard = 1'b1;
						req_age = '0;
						req_sent = 1'b1;
					end
				end
				ST_ARM: begin
					r.sp = takeoff_sp();
					if (!it.in_offboard) begin
						nxt = ST_REQ_OFFB;
					end else if (it.is_armed) begin
						nxt = ST_TAKEOFF;
					end else if (may_req) begin
						r.want_arm = 1'b1;
						req_age = '0;
						req_sent = 1'b1;
					end
				end
				ST_TAKEOFF: begin
					dx = ox - tgt_x;
					dy = oy - tgt_y;
					dz = oz - tgt_z;
					tol = longint'(reach_tol);
					r.sp = takeoff_sp();
					if (it.odom_valid && (dx * dx + dy * dy + dz * dz < tol * tol)) begin
						capture(1'b1, ox, oy, oz);
						nxt = ST_HOVER;
					end
				end
				ST_HOVER: begin
					r.sp = hover_sp();
					if (!it.in_offboard) begin
						nxt = ST_REQ_OFFB;
					end else if (fresh && cmd_en) begin
						if (cmd_kind == CMD_HOVER) capture(it.odom_valid, ox, oy, oz);
						else if (cmd_kind != CMD_IDLE) nxt = ST_COMMAND;
					end
				end
				ST_COMMAND: begin
					if (!it.in_offboard) begin
						nxt = ST_REQ_OFFB;
					end else if (!it.is_armed) begin
						nxt = ST_ARM;
					end else if (!fresh || !cmd_en || cmd_kind == CMD_IDLE ||
							cmd_kind == CMD_HOVER) begin
						capture(it.odom_valid, ox, oy, oz);
						nxt = ST_HOVER;
					end else if (cmd_kind == CMD_POS || cmd_kind == CMD_VEL) begin
						r.sp.kind = (cmd_kind == CMD_POS) ? SP_POS : SP_VEL;
						r.sp.x = cmd_x;
						r.sp.y = cmd_y;
						r.sp.z = cmd_z;
						r.sp.heading = cmd_hdg;
					end else begin
						r.sp = hover_sp();
					end
				end
			endcase
			mode = nxt;
			r.state = mode;
			if (req_age != '1) req_age++;
			if (cmd_age != '1) cmd_age++;
			modes_seen[mode] = 1'b1;
			if (r.want_offboard) offb_pulses++;
			if (r.want_arm) arm_pulses++;
			tick_results.push_back(r);
		endfunction

		function string show(result_t r);
			return $sformatf("state %0d sp %0d (%0d, %0d, %0d, %0d) offb %0b arm %0b",
				r.state, r.sp.kind, $signed(r.sp.x), $signed(r.sp.y),
				$signed(r.sp.z), $signed(r.sp.heading), r.want_offboard, r.want_arm);
		endfunction

		function void check_result(result_t got);
			result_t want;
			string bad;
			checked++;
			if (tick_results.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("ERROR: result with no tick pending: %s", show(got));
				return;
			end
			want = tick_results.pop_front();
			bad = "";
			if (got.state !== want.state) bad = {bad, " state"};
			if (got.sp.kind !== want.sp.kind) bad = {bad, " kind"};
			if (got.sp.x !== want.sp.x) bad = {bad, " x"};
			if (got.sp.y !== want.sp.y) bad = {bad, " y"};
			if (got.sp.z !== want.sp.z) bad = {bad, " z"};
			if (got.sp.heading !== want.sp.heading) bad = {bad, " heading"};
			if (got.want_offboard !== want.want_offboard) bad = {bad, " want_offboard"};
			if (got.want_arm !== want.want_arm) bad = {bad, " want_arm"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= ReportLimit) begin
					$display("ERROR: result %0d differs in%s", checked, bad);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ofms_pkg::*;
	import ofms_tb_pkg::*;

	localparam int ItemW = $bits(item_t);
	localparam int PosMax = (1 << (PosW - 1)) - 1;
	localparam int PosMin = -(1 << (PosW - 1));
	localparam int HdgMax = (1 << (HdgW - 1)) - 1;
	localparam int HdgMin = -(1 << (HdgW - 1));
	localparam int YawMax = 3142;
	localparam int AgeMax = (1 << AgeW) - 1;
	localparam int CntMax = (1 << CntW) - 1;
	localparam int TolMax = (1 << TolW) - 1;
	localparam int DrainCycles = 8;
	localparam logic [2:0] CMD_LAND = 3'd4;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = 1'b0;
	logic                link_up = 1'b0;
	logic                odom_valid = 1'b0;
	logic                in_offboard = 1'b0;
	logic                is_armed = 1'b0;
	logic                cmd_enable = 1'b0;
	logic [2:0]          cmd_kind = '0;
	logic [PosW-1:0]     val_x = '0;
	logic [PosW-1:0]     val_y = '0;
	logic [PosW-1:0]     val_z = '0;
	logic [HdgW-1:0]     val_heading = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          fsm_state;
	logic [1:0]          setpoint_kind;
	logic [PosW-1:0]     sp_x;
	logic [PosW-1:0]     sp_y;
	logic [PosW-1:0]     sp_z;
	logic [HdgW-1:0]     sp_heading;
	logic                want_offboard;
	logic                want_arm;

	flight_sequence_scoreboard sb = new();

	// Idling on both channels is on until the closing phase
	bit idle_on = 1'b1;
	int stall_left = 0;
	int n_ticks = 0;
	int n_cmds = 0;
	int n_settings = 0;
	int fails;
	result_t seen_result;

	offboard_flight_mode_sequencer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.link_up       (link_up),
		.odom_valid    (odom_valid),
		.in_offboard   (in_offboard),
		.is_armed      (is_armed),
		.cmd_enable    (cmd_enable),
		.cmd_kind      (cmd_kind),
		.val_x         (val_x),
		.val_y         (val_y),
		.val_z         (val_z),
		.val_heading   (val_heading),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fsm_state     (fsm_state),
		.setpoint_kind (setpoint_kind),
		.sp_x          (sp_x),
		.sp_y          (sp_y),
		.sp_z          (sp_z),
		.sp_heading    (sp_heading),
		.want_offboard (want_offboard),
		.want_arm      (want_arm)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Random point within +/- spread of a center, clamped to the field range
	function automatic logic [PosW-1:0] near(logic signed [PosW-1:0] c, int spread);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > PosMax) v = PosMax;
		if (v < PosMin) v = PosMin;
		return PosW'(v);
	endfunction

	function automatic item_t mk_tick(input bit link, odv, offb, armed, input int x, y, z);
		item_t it;
		it = '0;
		it.func = FUNC_TICK;
		it.link_up = link;
		it.odom_valid = odv;
		it.in_offboard = offb;
		it.is_armed = armed;
		it.val_x = PosW'(x);
		it.val_y = PosW'(y);
		it.val_z = PosW'(z);
		return it;
	endfunction

	function automatic item_t mk_cmd(input bit en, input logic [2:0] kind,
			input int x, y, z, h);
		item_t it;
		it = '0;
		it.func = FUNC_CMD;
		it.cmd_enable = en;
		it.cmd_kind = kind;
		it.val_x = PosW'(x);
		it.val_y = PosW'(y);
		it.val_z = PosW'(z);
		it.val_heading = HdgW'(h);
		return it;
	endfunction

	// Build a tick that mostly plays along with the launch sequence: raise the
	// flag the current mode waits for, and fly odometry close to the target so
	// that takeoff completes about half of the time. A few ticks stay noise.
	function automatic item_t make_tick();
		item_t it;
		int spread;
		it = item_t'(ItemW'({$urandom(), $urandom(), $urandom()}));
		it.func = FUNC_TICK;
		if (chance(8)) return it;
		case (sb.mode)
			ST_WAIT_LINK: it.link_up = chance(85);
			ST_WAIT_ODOM: it.odom_valid = chance(80);
			ST_INIT_SP: ;
			ST_REQ_OFFB: it.in_offboard = chance(30);
			ST_ARM: begin
				it.in_offboard = chance(95);
				it.is_armed = chance(35);
			end
			default: begin
				it.in_offboard = chance(97);
				it.is_armed = chance(97);
				it.odom_valid = chance(85);
			end
		endcase
		if (sb.mode >= ST_TAKEOFF && chance(80)) begin
			if (sb.mode == ST_TAKEOFF)
				spread = chance(50) ? int'(sb.reach_tol) / 2 + 1 : int'(sb.reach_tol) + 2;
			else
				spread = 3000;
			it.val_x = near(sb.tgt_x, spread);
			it.val_y = near(sb.tgt_y, spread);
			it.val_z = near(sb.tgt_z, spread);
		end
		return it;
	endfunction

	// Commands lean toward position and velocity, which lead into command mode;
	// the rest keep a random kind so that land and the unknown kinds show up.
	function automatic item_t make_cmd();
		item_t it;
		int pick;
		it = item_t'(ItemW'({$urandom(), $urandom(), $urandom()}));
		it.func = FUNC_CMD;
		it.cmd_enable = chance(85);
		pick = $urandom_range(0, 9);
		if (pick < 3) it.cmd_kind = CMD_POS;
		else if (pick < 6) it.cmd_kind = CMD_VEL;
		else if (pick == 6) it.cmd_kind = CMD_HOVER;
		else if (pick == 7) it.cmd_kind = CMD_IDLE;
		return it;
	endfunction

	// Present one item and hold it until the transfer; drop valid only for an
	// idle burst so a back-to-back item keeps valid high across the edge.
	task automatic send_item(input item_t it);
		int gap;
		if (idle_on && chance(25)) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{func, link_up, odom_valid, in_offboard, is_armed, cmd_enable, cmd_kind,
			val_x, val_y, val_z, val_heading} <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.accept_item(it);
		if (it.func == FUNC_CMD) n_cmds++;
		else n_ticks++;
	endtask

	task automatic put_reg(input reg_idx_t idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(val);
		@(posedge clk);
		sb.write_reg(idx, CfgDataW'(val));
	endtask

	task automatic load_settings(input int tx, ty, tz, yaw, tol, init_total, gap, tmo);
		put_reg(REG_TAKEOFF_X, tx);
		put_reg(REG_TAKEOFF_Y, ty);
		put_reg(REG_TAKEOFF_Z, tz);
		put_reg(REG_TAKEOFF_YAW, yaw);
		put_reg(REG_REACH_TOL, tol);
		put_reg(REG_INIT_TOTAL, init_total);
		put_reg(REG_REQ_GAP, gap);
		put_reg(REG_CMD_TIMEOUT, tmo);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Drop valid, wait for every owed result, then let a trailing command in
	// the input register drain before anything touches the registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.tick_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Commands come often once the vehicle hovers, rarely before
	task automatic run_phase(input int count);
		for (int n = 0; n < count; n++) begin
			if (sb.mode >= ST_HOVER ? chance(20) : chance(4)) send_item(make_cmd());
			else send_item(make_tick());
		end
	endtask

	// Walk the whole launch with hand-picked items under fast settings:
	// target (100, -200, 1500), tolerance 150, two initial setpoints, gap 3.
	task automatic run_directed();
		int tx, ty, tz, tol;
		tx = 100;
		ty = -200;
		tz = 1500;
		tol = 150;
		load_settings(tx, ty, tz, -YawMax, tol, 2, 3, 6);
		// no link yet: hold, odometry extremes ignored
		send_item(mk_tick(0, 1, 1, 1, PosMax, PosMax, PosMax));
		// early command with extreme fields, stored without a result
		send_item(mk_cmd(1, CMD_POS, PosMin, PosMax, -1, HdgMin));
		send_item(mk_tick(1, 0, 0, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 0, 0, PosMin, PosMin, PosMin));
		send_item(mk_tick(1, 1, 0, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 0, 0, 0, 0, 0));
		// first offboard request, then one too soon to repeat
		send_item(mk_tick(1, 1, 0, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 0, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 1, 0, 0, 0, 0));
		// offboard lost while arming: fall back and request again
		send_item(mk_tick(1, 1, 0, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 0, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 1, 0, 0, 0, 0));
		repeat (3) send_item(mk_tick(1, 1, 1, 0, 0, 0, 0));
		send_item(mk_tick(1, 1, 1, 1, 0, 0, 0));
		// exactly at the tolerance is not reached; no odometry is not reached
		send_item(mk_tick(1, 1, 1, 1, tx + tol, ty, tz));
		send_item(mk_tick(1, 0, 1, 1, tx, ty, tz));
		send_item(mk_tick(1, 1, 1, 1, tx + tol - 1, ty, tz));
		// hover command without odometry: hover on the takeoff target
		send_item(mk_cmd(1, CMD_HOVER, 0, 0, 0, 0));
		send_item(mk_tick(1, 0, 1, 1, 0, 0, 0));
		send_item(mk_cmd(1, CMD_VEL, PosMax, PosMin, 7, HdgMax));
		send_item(mk_tick(1, 1, 1, 1, 5, 6, 7));
		send_item(mk_tick(1, 1, 1, 1, 5, 6, 7));
		// land holds hover, then losing arm goes back to arming
		send_item(mk_cmd(1, CMD_LAND, 1, 2, 3, 4));
		send_item(mk_tick(1, 1, 1, 1, 8, 9, 10));
		send_item(mk_tick(1, 1, 1, 0, 8, 9, 10));
	endtask

	// Receiver: stall in random bursts while idling is on
	always @(posedge clk) begin
		if (stall_left == 0 && idle_on && arst_n && chance(6))
			stall_left = $urandom_range(1, 11);
		if (stall_left > 0 && idle_on) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Check every result transfer against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result.state = mode_t'(fsm_state);
			seen_result.sp.kind = setpoint_kind;
			seen_result.sp.x = sp_x;
			seen_result.sp.y = sp_y;
			seen_result.sp.z = sp_z;
			seen_result.sp.heading = sp_heading;
			seen_result.want_offboard = want_offboard;
			seen_result.want_arm = want_arm;
			sb.check_result(seen_result);
		end
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		settle();

		// Reset values; past the initial setpoints by now, so requests are slow
		load_settings(0, 0, 1500, 0, 150, 100, 500, 50);
		run_phase(200);
		settle();

		load_settings(-3000, 4000, 2500, YawMax, 300, 3, 2, 12);
		run_phase(250);
		settle();

		// Low extremes: request every tick, commands never fresh, widest tolerance
		load_settings(PosMin, PosMax, PosMin, -YawMax, TolMax, 0, 0, 0);
		run_phase(200);
		settle();

		// High extremes: takeoff never completes, requests never repeat,
		// commands never go stale
		load_settings(PosMax, PosMin, PosMax, YawMax, 0, CntMax, AgeMax, AgeMax);
		run_phase(150);
		settle();

		load_settings(1234, -5678, 900, -1000, 1000, 5, 5, 25);
		run_phase(250);
		settle();

		// Closing phase at full rate on both channels
		idle_on = 1'b0;
		load_settings(12, -34, 2000, 1000, 500, 1, 1, 4);
		run_phase(250);
		settle();

		fails = sb.mismatches;
		if (sb.tick_results.size() != 0) begin
			$display("ERROR: %0d owed results never arrived", sb.tick_results.size());
			fails += sb.tick_results.size();
		end
		$display("Sent %0d ticks and %0d commands under %0d register settings, %0d results checked.",
			n_ticks, n_cmds, n_settings, sb.checked);
		$display("Modes reached %b, offboard requests %0d, arm requests %0d.",
			sb.modes_seen, sb.offb_pulses, sb.arm_pulses);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
